FILE: hw/rtl/crh_pkg.sv
// crh_pkg: shared types, constants and the control program of the cube root unit
// used by crh_mul, crh_div, crh_seq, cube_root_halley and the testbench; no dependencies

package crh_pkg;

  // default number format, signed fixed point
  localparam int DEF_WORD_WIDTH = 32;
  localparam int DEF_FRAC_BITS  = 16;

  // configuration registers
  localparam int TOL_W      = 16;
  localparam int ITER_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 1'd1;

  localparam logic [TOL_W-1:0]  TOL_RESET   = 16'd1;
  localparam logic [ITER_W-1:0] MAXIT_RESET = 7'd48;
  localparam logic [ITER_W-1:0] CAP_LIMIT   = 7'd64;

  // program counter width of the control store
  localparam int PC_W = 4;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_START1,
    OP_SUM,
    OP_START2,
    OP_UPDATE,
    OP_EMIT
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_DONE,
    C_BUSY,
    C_MORE,
    C_OUT_BLK
  } cond_t;

  // one control word
  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
    logic more;
    logic out_blk;
  } flags_t;

  // program addresses
  localparam logic [PC_W-1:0] PC_LOAD  = 4'd0;
  localparam logic [PC_W-1:0] PC_ZCHK  = 4'd1;
  localparam logic [PC_W-1:0] PC_STEP  = 4'd2;
  localparam logic [PC_W-1:0] PC_WAIT1 = 4'd3;
  localparam logic [PC_W-1:0] PC_SUM   = 4'd4;
  localparam logic [PC_W-1:0] PC_DIV2  = 4'd5;
  localparam logic [PC_W-1:0] PC_WAIT2 = 4'd6;
  localparam logic [PC_W-1:0] PC_UPD   = 4'd7;
  localparam logic [PC_W-1:0] PC_LOOP  = 4'd8;
  localparam logic [PC_W-1:0] PC_EMIT  = 4'd9;
  localparam logic [PC_W-1:0] PC_BACK  = 4'd10;

  // control store: jump to target when cond holds, else fall through
  function automatic ctrl_t crh_rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      PC_LOAD:  w = '{op: OP_LOAD,   cond: C_NO_START, target: PC_LOAD};
      PC_ZCHK:  w = '{op: OP_NOP,    cond: C_DONE,     target: PC_EMIT};
      PC_STEP:  w = '{op: OP_START1, cond: C_NEVER,    target: PC_LOAD};
      PC_WAIT1: w = '{op: OP_NOP,    cond: C_BUSY,     target: PC_WAIT1};
      PC_SUM:   w = '{op: OP_SUM,    cond: C_NEVER,    target: PC_LOAD};
      PC_DIV2:  w = '{op: OP_START2, cond: C_NEVER,    target: PC_LOAD};
      PC_WAIT2: w = '{op: OP_NOP,    cond: C_BUSY,     target: PC_WAIT2};
      PC_UPD:   w = '{op: OP_UPDATE, cond: C_NEVER,    target: PC_LOAD};
      PC_LOOP:  w = '{op: OP_NOP,    cond: C_MORE,     target: PC_STEP};
      PC_EMIT:  w = '{op: OP_EMIT,   cond: C_OUT_BLK,  target: PC_EMIT};
      PC_BACK:  w = '{op: OP_NOP,    cond: C_ALWAYS,   target: PC_LOAD};
      default:  w = '{op: OP_NOP,    cond: C_ALWAYS,   target: PC_LOAD};
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/crh_mul.sv
// crh_mul: serial shift-add squarer, (x * x) >> FRAC_BITS saturated to the word range
// depends on crh_pkg

module crh_mul import crh_pkg::*; #(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [WORD_WIDTH-2:0] opnd,
  output logic                  busy,
  output logic [WORD_WIDTH-2:0] res
);

  localparam int MW    = WORD_WIDTH - 1;
  localparam int CNT_W = $clog2(MW + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(MW);

  logic [MW-1:0]   mcand;
  logic [2*MW-1:0] prod;
  logic [CNT_W-1:0] cnt;
  logic [MW:0]     psum;
  logic [2*MW-1:0] shifted;

  // add the multiplicand when the low multiplier bit is set
  assign psum = {1'b0, prod[2*MW-1:MW]} + (prod[0] ? {1'b0, mcand} : '0);

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= STEPS;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // product register, multiplier bits shift out at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= opnd;
      prod  <= {{MW{1'b0}}, opnd};
    end else if (cnt != '0) begin
      prod <= {psum, prod[MW-1:1]};
    end
  end

  // drop the fraction and saturate
  assign shifted = prod >> FRAC_BITS;
  assign res     = (|shifted[2*MW-1:MW]) ? '1 : shifted[MW-1:0];
  assign busy    = (cnt != '0);

endmodule

FILE: hw/rtl/crh_div.sv
// crh_div: restoring divider, (x << FRAC_BITS) / d one bit a cycle, saturated
// depends on crh_pkg

module crh_div import crh_pkg::*; #(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [WORD_WIDTH:0]   x,
  input  logic [WORD_WIDTH-2:0] d,
  output logic                  busy,
  output logic [WORD_WIDTH-2:0] res
);

  localparam int MW    = WORD_WIDTH - 1;
  localparam int NUM_W = WORD_WIDTH + 1 + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(NUM_W);

  logic [NUM_W-1:0] num;
  logic [MW-1:0]    rem;
  logic [MW-1:0]    quo;
  logic [MW-1:0]    dvs;
  logic             ovf;
  logic [CNT_W-1:0] cnt;
  logic [MW:0]      trial;
  logic [MW:0]      diff;
  logic             ge;

  // trial subtract of the divisor from the partial remainder
  assign trial = {rem, num[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= STEPS;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // one quotient bit per cycle; a bit lost off the top means overflow
  always_ff @(posedge clk) begin
    if (start) begin
      num <= {x, {FRAC_BITS{1'b0}}};
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
      dvs <= d;
    end else if (cnt != '0) begin
      num <= {num[NUM_W-2:0], 1'b0};
      rem <= ge ? diff[MW-1:0] : trial[MW-1:0];
      quo <= {quo[MW-2:0], ge};
      ovf <= ovf | quo[MW-1];
    end
  end

  // zero divisor or overflow gives the largest magnitude
  assign res  = (ovf || dvs == '0) ? '1 : quo;
  assign busy = (cnt != '0);

endmodule

FILE: hw/rtl/crh_seq.sv
// crh_seq: program counter and control store of the cube root unit
// depends on crh_pkg

module crh_seq import crh_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            jump;

  // fetch and branch decision
  always_comb begin
    ctrl = crh_rom(pc);
    case (ctrl.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_START: jump = !flags.start;
      C_DONE:     jump = flags.done;
      C_BUSY:     jump = flags.busy;
      C_MORE:     jump = flags.more;
      C_OUT_BLK:  jump = flags.out_blk;
      default:    jump = 1'b1;
    endcase
    pc_next = jump ? ctrl.target : pc + 1'b1;
  end

  // program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

FILE: hw/rtl/cube_root_halley.sv
// cube_root_halley: top level, datapath registers, config registers and output register
// depends on crh_pkg, crh_seq, crh_mul, crh_div

// Cube root of a signed fixed-point value (WORD_WIDTH bits, FRAC_BITS fraction bits)
// by Halley iteration, starting from the operand itself and stopping when a step
// moves the estimate by no more than tolerance or after max_iterations steps
// (0 acts as 1, above 64 acts as 64). A zero operand returns at once with root 0,
// no steps and converged set. One item is processed at a time. The default format
// is Q16.16. The length of each Halley step is set by the two serial divisions that
// share one bit-per-cycle divider; the squaring runs alongside the first division.
// A finished result waits while the output register is full. A new item is taken
// while the previous result still waits in the output register.

module cube_root_halley import crh_pkg::*; #(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [WORD_WIDTH-1:0] operand,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [WORD_WIDTH-1:0] root,
  output logic [ITER_W-1:0]            iterations_used,
  output logic                         converged
);

  localparam int MW    = WORD_WIDTH - 1;
  localparam int CMP_W = (MW > TOL_W) ? MW : TOL_W;

  ctrl_t  ctrl;
  flags_t flags;

  // configuration registers
  logic [TOL_W-1:0]  tolerance;
  logic [ITER_W-1:0] max_iterations;

  // working registers
  logic [WORD_WIDTH-1:0] mag;
  logic                  neg;
  logic [MW-1:0]         est;
  logic [MW-1:0]         den;
  logic [ITER_W-1:0]     steps;
  logic [ITER_W-1:0]     cap;
  logic                  done;

  // unit connections
  logic              mul_busy;
  logic [MW-1:0]     mul_res;
  logic              div_busy;
  logic [MW-1:0]     div_res;
  logic              div_start;
  logic [WORD_WIDTH:0] div_x;
  logic [MW-1:0]     div_d;

  // combinational helpers
  logic                  accept;
  logic                  out_blk;
  logic [WORD_WIDTH-1:0] in_bits;
  logic [WORD_WIDTH-1:0] in_mag;
  logic [WORD_WIDTH:0]   mag3;
  logic [MW+1:0]         den_full;
  logic [MW:0]           est_sum;
  logic [MW-1:0]         est_next;
  logic [MW-1:0]         delta;
  logic [ITER_W-1:0]     cap_eff;
  logic [WORD_WIDTH-1:0] root_mag;

  // sequencer
  crh_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // squarer for est * est
  crh_mul #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.op == OP_START1),
    .opnd  (est),
    .busy  (mul_busy),
    .res   (mul_res)
  );

  // shared divider: n / est first, then 3n / den
  assign div_start = (ctrl.op == OP_START1) || (ctrl.op == OP_START2);
  assign div_x     = (ctrl.op == OP_START2) ? mag3 : {1'b0, mag};
  assign div_d     = (ctrl.op == OP_START2) ? den : est;

  crh_div #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .x     (div_x),
    .d     (div_d),
    .busy  (div_busy),
    .res   (div_res)
  );

  // handshake and status
  assign in_ready = (ctrl.op == OP_LOAD);
  assign accept   = in_valid && in_ready;
  assign out_blk  = out_valid && !out_ready;

  always_comb begin
    flags.start   = accept;
    flags.busy    = mul_busy | div_busy;
    flags.done    = done;
    flags.more    = !done && (steps < cap);
    flags.out_blk = out_blk;
  end

  // operand magnitude and effective step cap
  assign in_bits = operand;
  assign in_mag  = in_bits[WORD_WIDTH-1] ? (~in_bits + 1'b1) : in_bits;

  always_comb begin
    if (max_iterations == '0) begin
      cap_eff = ITER_W'(1);
    end else if (max_iterations > CAP_LIMIT) begin
      cap_eff = CAP_LIMIT;
    end else begin
      cap_eff = max_iterations;
    end
  end

  // step arithmetic
  assign mag3     = {mag, 1'b0} + {1'b0, mag};
  assign den_full = {1'b0, mul_res, 1'b0} + {2'b00, div_res};
  assign est_sum  = {1'b0, est} + {1'b0, div_res};
  assign est_next = est_sum[MW:1];
  assign delta    = (est_next > est) ? (est_next - est) : (est - est_next);
  assign root_mag = {1'b0, est};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance      <= TOL_RESET;
      max_iterations <= MAXIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOLERANCE: tolerance      <= cfg_data[TOL_W-1:0];
        REG_MAX_ITER:  max_iterations <= cfg_data[ITER_W-1:0];
        default:       ;
      endcase
    end
  end

  // working registers driven by the current control word
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (accept) begin
          mag   <= in_mag;
          neg   <= in_bits[WORD_WIDTH-1];
          est   <= in_mag[WORD_WIDTH-1] ? '1 : in_mag[MW-1:0];
          steps <= '0;
          cap   <= cap_eff;
          done  <= (in_mag == '0);
        end
      end
      OP_SUM: begin
        den <= (den_full[MW+1:MW] != 2'b00) ? '1 : den_full[MW-1:0];
      end
      OP_UPDATE: begin
        est   <= est_next;
        steps <= steps + 1'b1;
        done  <= (CMP_W'(delta) <= CMP_W'(tolerance));
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_EMIT && !out_blk) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT && !out_blk) begin
      root            <= neg ? (~root_mag + 1'b1) : root_mag;
      iterations_used <= steps;
      converged       <= done;
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for the cube_root_halley fixed-point cube root unit
// depends on crh_pkg and cube_root_halley; holds its own Halley predictor in a scoreboard class

module testbench;
  import crh_pkg::*;

  localparam int WW = DEF_WORD_WIDTH;
  localparam int FB = DEF_FRAC_BITS;
  localparam logic [63:0] MAG_MAX = (64'd1 << (WW - 1)) - 64'd1;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int RANDOM_ITEMS = 120;
  localparam int PHASE_ITEMS = 20;

  // one expected result, with the operand that caused it
  typedef struct {
    logic [WW-1:0]     operand;
    logic [WW-1:0]     root;
    logic [ITER_W-1:0] steps;
    logic              conv;
  } root_rec_t;

  // predicts each root from the current register copy and checks results in order
  class cube_root_scoreboard;
    logic [TOL_W-1:0]  tolerance;
    logic [ITER_W-1:0] max_iter;
    root_rec_t         pending_roots[$];
    int                failures;
    int                operands_seen;
    int                roots_checked;
    int                capped_roots;

    function new();
      tolerance = TOL_RESET;
      max_iter = MAXIT_RESET;
      failures = 0;
      operands_seen = 0;
      roots_checked = 0;
      capped_roots = 0;
    endfunction

    function void set_registers(logic [TOL_W-1:0] tol, logic [ITER_W-1:0] cap);
      tolerance = tol;
      max_iter = cap;
    endfunction

    function int outstanding();
      return pending_roots.size();
    endfunction

    // (x << FB) / d truncated, saturated to the largest magnitude
    static function logic [63:0] quot_sat(logic [63:0] x, logic [63:0] d);
      logic [63:0] q;
      if (d == 64'd0) return MAG_MAX;
      q = (x << FB) / d;
      return (q > MAG_MAX) ? MAG_MAX : q;
    endfunction

    // (u * u) >> FB, saturated
    static function logic [63:0] square_sat(logic [63:0] u);
      logic [63:0] p;
      p = (u * u) >> FB;
      return (p > MAG_MAX) ? MAG_MAX : p;
    endfunction

    function root_rec_t halley_root(logic [WW-1:0] n);
      root_rec_t   r;
      logic        neg;
      logic [63:0] a, u, q1, den, q2, nxt, delta, signed_root;
      int          cap, steps;
      bit          done;
      r.operand = n;
      neg = n[WW-1];
      a = {{(64 - WW){1'b0}}, n};
      if (neg) a = (64'd1 << WW) - a;
      // zero operand returns at once
      if (a == 64'd0) begin
        r.root = '0;
        r.steps = '0;
        r.conv = 1'b1;
        return r;
      end
      cap = int'(max_iter);
      if (cap == 0) cap = 1;
      if (cap > int'(CAP_LIMIT)) cap = int'(CAP_LIMIT);
      // most negative operand: start clamped, quotients use the exact magnitude
      u = (a > MAG_MAX) ? MAG_MAX : a;
      steps = 0;
      done = 1'b0;
      while (!done && steps < cap) begin
        q1 = quot_sat(a, u);
        den = 2 * square_sat(u) + q1;
        if (den > MAG_MAX) den = MAG_MAX;
        q2 = quot_sat(3 * a, den);
        nxt = (u + q2) >> 1;
        delta = (nxt > u) ? nxt - u : u - nxt;
        u = nxt;
        steps++;
        if (delta <= {48'd0, tolerance}) done = 1'b1;
      end
      signed_root = neg ? ((64'd1 << WW) - u) : u;
      r.root = signed_root[WW-1:0];
      r.steps = steps[ITER_W-1:0];
      r.conv = done;
      return r;
    endfunction

    function void note_operand(logic [WW-1:0] n);
      pending_roots.push_back(halley_root(n));
      operands_seen++;
    endfunction

    function void check_root(logic [WW-1:0] got_root, logic [ITER_W-1:0] got_steps,
                             logic got_conv);
      root_rec_t want;
      if (pending_roots.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: root %h steps %0d conv %0b", got_root, got_steps,
                   got_conv);
        return;
      end
      want = pending_roots.pop_front();
      roots_checked++;
      if (!want.conv) capped_roots++;
      if (got_root !== want.root || got_steps !== want.steps || got_conv !== want.conv) begin
        failures++;
        if (failures <= 10)
          $display("mismatch for operand %h: expected root %h steps %0d conv %0b, got %h %0d %0b",
                   want.operand, want.root, want.steps, want.conv,
                   got_root, got_steps, got_conv);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_TOLERANCE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [WW-1:0]  operand = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [WW-1:0]  root;
  logic [ITER_W-1:0]     iterations_used;
  logic                  converged;

  cube_root_scoreboard sb;
  int send_idle_pct = 6;
  int recv_idle_pct = 45;
  int settings_used = 0;
  int cycle_count = 0;

  cube_root_halley u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operand(operand),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .root(root),
    .iterations_used(iterations_used),
    .converged(converged)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // item monitors, values sampled from before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_root(root, iterations_used, converged);
      if (in_valid && in_ready) sb.note_operand(operand);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending", cycle_count,
               sb.outstanding());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // random gap, then one operand held until accepted
  task automatic send_operand(logic [WW-1:0] n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      operand <= $urandom;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operand <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending and wait until every root has come back
  task automatic drain_roots();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers, written back to back while the unit is idle
  task automatic write_registers(logic [TOL_W-1:0] tol, logic [ITER_W-1:0] cap);
    cfg_we <= 1'b1;
    cfg_index <= REG_TOLERANCE;
    cfg_data <= tol;
    @(posedge clk);
    cfg_index <= REG_MAX_ITER;
    cfg_data <= {{(CFG_DATA_W - ITER_W){1'b0}}, cap};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_registers(tol, cap);
    settings_used++;
  endtask

  // mix of wide random, small, exact cubes, near the ends and fraction only
  function automatic logic [WW-1:0] pick_operand();
    logic [WW-1:0] v;
    int            k;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = $urandom_range(0, 1 << 20);
      6, 7: begin
        k = $urandom_range(0, 31);
        v = WW'(k * k * k) << FB;
      end
      8:          v = 32'h7FFF_FFFF - $urandom_range(0, 15);
      default:    v = $urandom_range(1, 65535);
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  function automatic logic [TOL_W-1:0] pick_tolerance();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return TOL_W'($urandom_range(0, 65535));
      default: return TOL_W'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [ITER_W-1:0] pick_cap();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ITER_W'($urandom_range(65, 127));
      2:       return ITER_W'($urandom_range(1, 4));
      default: return ITER_W'($urandom_range(1, 64));
    endcase
  endfunction

  logic [WW-1:0] reset_ops[] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                                 32'hFFFF_0000, 32'h0008_0000, 32'h001B_0000,
                                 32'hFFF8_0000, 32'h0000_0002, 32'h5555_5555,
                                 32'hAAAA_AAAA, 32'h1234_5678};

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset register values, field extremes and exact cubes
    foreach (reset_ops[i]) send_operand(reset_ops[i]);
    drain_roots();

    // zero tolerance at the top cap
    write_registers('0, 7'd64);
    send_operand(32'h0000_0001);
    send_operand(32'h7FFF_FFFF);
    send_operand(32'hFFFD_0000);
    drain_roots();

    // widest tolerance with a zero cap, which acts as one step
    write_registers('1, '0);
    send_operand(32'h8000_0000);
    send_operand(32'h0040_0000);
    drain_roots();

    // cap beyond the limit acts as 64
    write_registers(16'd3, '1);
    send_operand(32'hC000_0000);
    send_operand(32'h0000_0010);
    drain_roots();

    // random phases: sender idles lightly, then receiver, then neither
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_ITEMS == 0) begin
        if (i != 0) drain_roots();
        if (i < RANDOM_ITEMS / 3) begin
          send_idle_pct = 6;
          recv_idle_pct = 45;
        end else if (i < 2 * RANDOM_ITEMS / 3) begin
          send_idle_pct = 45;
          recv_idle_pct = 6;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        write_registers(pick_tolerance(), pick_cap());
      end
      send_operand(pick_operand());
    end
    drain_roots();

    $display("covered %0d operands under %0d register settings plus reset values",
             sb.operands_seen, settings_used);
    $display("%0d roots checked, %0d stopped at the iteration cap",
             sb.roots_checked, sb.capped_roots);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d failures, %0d roots never returned", sb.failures, sb.outstanding());
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
